@@ hw/rtl/dfa_pkg.sv @@
`timescale 1ns / 1ps

package dfa_pkg;

  // default table sizes
  localparam int DEF_MAX_STATES  = 16;
  localparam int DEF_MAX_SYMBOLS = 8;

  // input item op codes
  localparam logic [1:0] OP_WRITE_ALPHA = 2'd0;
  localparam logic [1:0] OP_WRITE_TRANS = 2'd1;
  localparam logic [1:0] OP_FEED        = 2'd2;
  localparam logic [1:0] OP_END         = 2'd3;

  // verdict codes
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [1:0] VERDICT_REJECT  = 2'd1;
  localparam logic [1:0] VERDICT_INVALID = 2'd2;

  // register word indexes (byte address bits 3:2)
  localparam logic [1:0] REG_START_STATE  = 2'd0;
  localparam logic [1:0] REG_ACCEPT_MASK  = 2'd1;
  localparam logic [1:0] REG_SYMBOL_COUNT = 2'd2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef struct packed {
    logic [3:0]  start_state;
    logic [15:0] accept_mask;
    logic [3:0]  symbol_count;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_alpha;
    logic load_trans;
    logic feed;
    logic finish;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

@@ hw/rtl/dfa_regs.sv @@
`timescale 1ns / 1ps

module dfa_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfa_pkg::ADDR_W-1:0] paddr,
  input  logic [dfa_pkg::DATA_W-1:0] pwdata,
  output logic [dfa_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dfa_pkg::cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_state  <= 4'd0;
      cfg.accept_mask  <= 16'd0;
      cfg.symbol_count <= 4'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        dfa_pkg::REG_START_STATE:  cfg.start_state  <= pwdata[3:0];
        dfa_pkg::REG_ACCEPT_MASK:  cfg.accept_mask  <= pwdata[15:0];
        dfa_pkg::REG_SYMBOL_COUNT: cfg.symbol_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      dfa_pkg::REG_START_STATE:  prdata = {28'd0, cfg.start_state};
      dfa_pkg::REG_ACCEPT_MASK:  prdata = {16'd0, cfg.accept_mask};
      dfa_pkg::REG_SYMBOL_COUNT: prdata = {28'd0, cfg.symbol_count};
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/dfa_ctrl.sv @@
`timescale 1ns / 1ps

module dfa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       op,
  input  dfa_pkg::status_t status,
  output logic             in_stall,
  output dfa_pkg::cmd_t    cmd
);

  localparam logic ST_READY = 1'b0;
  localparam logic ST_STEP  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  // stall any item in ST_STEP, an end item while a result waits
  assign in_stall = (state == ST_STEP) || ((op == dfa_pkg::OP_END) && status.out_busy);
  assign accept   = in_valid && !in_stall;

  // commands to the datapath
  always_comb begin
    cmd.load_alpha = accept && (op == dfa_pkg::OP_WRITE_ALPHA);
    cmd.load_trans = accept && (op == dfa_pkg::OP_WRITE_TRANS);
    cmd.feed       = accept && (op == dfa_pkg::OP_FEED);
    cmd.finish     = accept && (op == dfa_pkg::OP_END);
    cmd.step       = (state == ST_STEP);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_READY: begin
        if (accept && (op == dfa_pkg::OP_FEED)) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: state_next = ST_READY;
      default: state_next = ST_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/dfa_dp.sv @@
`timescale 1ns / 1ps

module dfa_dp #(
  parameter int MAX_STATES  = dfa_pkg::DEF_MAX_STATES,
  parameter int MAX_SYMBOLS = dfa_pkg::DEF_MAX_SYMBOLS
) (
  input  logic              clk,
  input  logic              rst,
  input  dfa_pkg::cmd_t     cmd,
  input  dfa_pkg::cfg_t     cfg,
  input  logic [7:0]        symbol,
  input  logic [3:0]        row_state,
  input  logic [2:0]        column,
  input  logic [3:0]        target_state,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [1:0]        verdict,
  output logic [3:0]        final_state,
  output dfa_pkg::status_t  status
);

  localparam int SW        = $clog2(MAX_STATES);
  localparam int CW        = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int MEM_DEPTH = 1 << (SW + CW);

  // state index modulo MAX_STATES by repeated subtraction
  function automatic logic [SW-1:0] clip(input logic [3:0] v);
    logic [8:0] r;
    r = {5'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 9'(MAX_STATES)) begin
        r = r - 9'(MAX_STATES);
      end
    end
    return r[SW-1:0];
  endfunction

  logic [7:0]       alpha [MAX_SYMBOLS];
  logic [SW-1:0]    trans_mem [MEM_DEPTH];
  logic [SW-1:0]    rd_data;
  logic [SW-1:0]    cur;
  logic             idle;
  logic             invalid_seen;
  logic             pend_hit;
  logic [SW-1:0]    present;
  logic [SW+3:0]    present_wide;
  logic [CW+2:0]    col_ext;
  logic             col_ok;
  logic             hit;
  logic [CW-1:0]    hit_col;
  logic             accepting;
  logic [SW+CW-1:0] wr_addr;
  logic [SW+CW-1:0] rd_addr;

  assign present      = idle ? clip(cfg.start_state) : cur;
  assign present_wide = {4'd0, present};
  assign col_ext      = {{CW{1'b0}}, column};
  assign col_ok       = (col_ext < (CW + 3)'(MAX_SYMBOLS));
  assign wr_addr      = {clip(row_state), col_ext[CW-1:0]};
  assign rd_addr      = {present, hit_col};
  assign accepting    = ((present_wide >> 4) == '0) && cfg.accept_mask[present_wide[3:0]];
  assign status.out_busy = out_valid && out_stall;

  // alphabet match, lowest active column wins
  always_comb begin
    hit     = 1'b0;
    hit_col = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if ((k < int'(cfg.symbol_count)) && (alpha[k] == symbol)) begin
        hit     = 1'b1;
        hit_col = CW'(k);
      end
    end
  end

  // alphabet table
  always_ff @(posedge clk) begin
    if (cmd.load_alpha && col_ok) begin
      alpha[col_ext[CW-1:0]] <= symbol;
    end
  end

  // transition table memory
  always_ff @(posedge clk) begin
    if (cmd.load_trans && col_ok) begin
      trans_mem[wr_addr] <= clip(target_state);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed) begin
      rd_data <= trans_mem[rd_addr];
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      idle         <= 1'b1;
      invalid_seen <= 1'b0;
      pend_hit     <= 1'b0;
    end else if (cmd.feed) begin
      idle     <= 1'b0;
      pend_hit <= !invalid_seen && hit;
      if (!invalid_seen && !hit) begin
        invalid_seen <= 1'b1;
      end
    end else if (cmd.finish) begin
      idle         <= 1'b1;
      invalid_seen <= 1'b0;
    end else if (cmd.step) begin
      pend_hit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed) begin
      cur <= present;
    end else if (cmd.step && pend_hit) begin
      cur <= rd_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      final_state <= present_wide[3:0];
      if (invalid_seen) begin
        verdict <= dfa_pkg::VERDICT_INVALID;
      end else if (accepting) begin
        verdict <= dfa_pkg::VERDICT_ACCEPT;
      end else begin
        verdict <= dfa_pkg::VERDICT_REJECT;
      end
    end
  end

endmodule

@@ hw/rtl/table_driven_dfa_recognizer.sv @@
`timescale 1ns / 1ps
// Programmable DFA string recognizer.
// Input channel (in_valid/in_stall): op-coded items. Alphabet writes and
// transition writes load the tables; feed items carry one character of a
// string; an end item closes the string and produces one result.
// Output channel (out_valid/out_stall): verdict (accepted, not accepted,
// invalid character seen) and the final state, one transfer per end item.
// Registers (start state, accept mask, symbol count) sit on the APB port.
// Write and end items need no extra step. A feed item does the alphabet
// match and registered transition table read, then the state update in a
// stalling step. The result is valid the cycle after its end item.
// Reset clears the registers to defaults, empties the result register and
// returns to the start state; the tables are not cleared and must be
// loaded before use. While a result waits under out_stall, write and feed
// items are still taken; a second end item is held off until the waiting
// result has been transferred.
module table_driven_dfa_recognizer #(
  parameter int MAX_STATES  = dfa_pkg::DEF_MAX_STATES,
  parameter int MAX_SYMBOLS = dfa_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfa_pkg::ADDR_W-1:0] paddr,
  input  logic [dfa_pkg::DATA_W-1:0] pwdata,
  output logic [dfa_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [7:0]                 symbol,
  input  logic [3:0]                 row_state,
  input  logic [2:0]                 column,
  input  logic [3:0]                 target_state,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 verdict,
  output logic [3:0]                 final_state
);

  dfa_pkg::cfg_t    cfg;
  dfa_pkg::cmd_t    cmd;
  dfa_pkg::status_t status;

  dfa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  dfa_dp #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .symbol       (symbol),
    .row_state    (row_state),
    .column       (column),
    .target_state (target_state),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .verdict      (verdict),
    .final_state  (final_state),
    .status       (status)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 125;

  typedef struct {
    logic [1:0] op;
    logic [7:0] sym;
    logic [3:0] row;
    logic [2:0] col;
    logic [3:0] tgt;
  } dfa_item_t;

  typedef struct {
    logic [1:0] verdict;
    logic [3:0] state;
  } verdict_t;

  // block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dfa_pkg::ADDR_W-1:0] paddr = '0;
  logic [dfa_pkg::DATA_W-1:0] pwdata = '0;
  logic [dfa_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [7:0] symbol = '0;
  logic [3:0] row_state = '0;
  logic [2:0] column = '0;
  logic [3:0] target_state = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] verdict;
  logic [3:0] final_state;

  // stimulus bookkeeping
  dfa_item_t pending_items[$];
  verdict_t verdict_queue[$];
  int issued = 0;
  int taken = 0;
  int queued_total = 0;
  int mismatches = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  // generator view of the alphabet, in queue order
  logic [7:0] gen_alpha[8];
  logic [3:0] gen_count = 4'd1;

  // automaton mirror
  logic [3:0] m_start = 4'd0;
  logic [15:0] m_accept = 16'd0;
  logic [3:0] m_count = 4'd1;
  logic [3:0] m_state = 4'd0;
  bit m_bad = 1'b0;
  bit m_fresh = 1'b1;
  logic [7:0] m_alpha[8];
  logic [3:0] m_next[16][8];

  table_driven_dfa_recognizer uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .symbol(symbol),
    .row_state(row_state),
    .column(column),
    .target_state(target_state),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .final_state(final_state)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // advance the automaton by one accepted item
  task automatic step_automaton(input logic [1:0] i_op, input logic [7:0] i_sym,
                                input logic [3:0] i_row, input logic [2:0] i_col,
                                input logic [3:0] i_tgt);
    logic [3:0] s;
    int n;
    int k;
    int hit_col;
    verdict_t res;
    s = m_fresh ? m_start : m_state;
    n = (m_count > 4'd8) ? 8 : int'(m_count);
    hit_col = -1;
    case (i_op)
      dfa_pkg::OP_WRITE_ALPHA: begin
        m_alpha[i_col] = i_sym;
      end
      dfa_pkg::OP_WRITE_TRANS: begin
        m_next[i_row][i_col] = i_tgt;
      end
      dfa_pkg::OP_FEED: begin
        m_fresh = 1'b0;
        m_state = s;
        if (!m_bad) begin
          // lowest active column wins
          for (k = 0; k < n; k++) begin
            if (hit_col < 0 && m_alpha[k] == i_sym) hit_col = k;
          end
          if (hit_col >= 0) m_state = m_next[s][hit_col];
          else m_bad = 1'b1;
        end
      end
      default: begin
        res.state = s;
        if (m_bad) res.verdict = dfa_pkg::VERDICT_INVALID;
        else if (m_accept[s]) res.verdict = dfa_pkg::VERDICT_ACCEPT;
        else res.verdict = dfa_pkg::VERDICT_REJECT;
        verdict_queue.insert(verdict_queue.size(), res);
        m_bad = 1'b0;
        m_fresh = 1'b1;
        m_state = m_start;
      end
    endcase
  endtask

  // input transfers feed the mirror, output transfers are checked
  always @(posedge clk) begin
    verdict_t exp_res;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        step_automaton(op, symbol, row_state, column, target_state);
        taken++;
      end
      if (out_valid && !out_stall) begin
        if (verdict_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: verdict %0d state %0d", verdict, final_state);
        end else begin
          exp_res = verdict_queue.pop_front();
          if (verdict !== exp_res.verdict || final_state !== exp_res.state) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected verdict %0d state %0d, got verdict %0d state %0d",
                       exp_res.verdict, exp_res.state, verdict, final_state);
          end
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    dfa_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken != issued) begin
      // stalled transfer holds its payload
    end else if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      nxt = pending_items.pop_front();
      op <= nxt.op;
      symbol <= nxt.sym;
      row_state <= nxt.row;
      column <= nxt.col;
      target_state <= nxt.tgt;
      in_valid <= 1'b1;
      issued++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt++;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 26);
    end
  end

  function automatic int gen_cols();
    return (gen_count > 4'd8) ? 8 : int'(gen_count);
  endfunction

  // a byte that some active column holds, or any byte with no column active
  function automatic logic [7:0] known_char();
    if (gen_cols() == 0) return 8'($urandom);
    return gen_alpha[$urandom_range(0, gen_cols() - 1)];
  endfunction

  // a byte that no active column holds
  function automatic logic [7:0] stranger_byte();
    logic [7:0] c;
    bit clash;
    do begin
      c = 8'($urandom);
      clash = 1'b0;
      for (int k = 0; k < gen_cols(); k++) begin
        if (gen_alpha[k] == c) clash = 1'b1;
      end
    end while (clash);
    return c;
  endfunction

  task automatic push_item(input logic [1:0] i_op, input logic [7:0] i_sym,
                           input logic [3:0] i_row, input logic [2:0] i_col,
                           input logic [3:0] i_tgt);
    dfa_item_t it;
    it.op = i_op;
    it.sym = i_sym;
    it.row = i_row;
    it.col = i_col;
    it.tgt = i_tgt;
    if (i_op == dfa_pkg::OP_WRITE_ALPHA) gen_alpha[i_col] = i_sym;
    pending_items.insert(pending_items.size(), it);
    queued_total++;
  endtask

  task automatic push_feed(input logic [7:0] c);
    push_item(dfa_pkg::OP_FEED, c, 4'($urandom), 3'($urandom), 4'($urandom));
  endtask

  task automatic push_end();
    push_item(dfa_pkg::OP_END, 8'($urandom), 4'($urandom), 3'($urandom), 4'($urandom));
  endtask

  task automatic push_table_write();
    if ($urandom_range(0, 1) == 0)
      push_item(dfa_pkg::OP_WRITE_ALPHA, 8'($urandom), 4'($urandom), 3'($urandom),
                4'($urandom));
    else
      push_item(dfa_pkg::OP_WRITE_TRANS, 8'($urandom), 4'($urandom), 3'($urandom),
                4'($urandom));
  endtask

  // wait until every item is taken and every result has come back
  task automatic settle();
    while (pending_items.size() > 0 || taken != issued || verdict_queue.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] s, input logic [15:0] mask,
                            input logic [3:0] cnt);
    write_reg(dfa_pkg::REG_START_STATE, {28'd0, s});
    write_reg(dfa_pkg::REG_ACCEPT_MASK, {16'd0, mask});
    write_reg(dfa_pkg::REG_SYMBOL_COUNT, {28'd0, cnt});
    m_start = s;
    m_accept = mask;
    m_count = cnt;
    gen_count = cnt;
  endtask

  // mostly well-formed strings, some noise and unfinished strings
  task automatic random_phase(input int budget);
    int stop_at;
    int len;
    int r;
    stop_at = queued_total + budget;
    while (queued_total < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_table_write();
      end else if (r < 12) begin
        push_feed(8'($urandom));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 4) push_table_write();
          else if (r < 10) push_feed(stranger_byte());
          else if (r < 14) push_feed(8'($urandom));
          else push_feed(known_char());
        end
        if ($urandom_range(0, 19) != 0) push_end();
      end
    end
  endtask

  initial begin
    logic [15:0] mask;
    logic [3:0] cnt;
    int pick;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // load every table entry before any lookup
    push_item(dfa_pkg::OP_WRITE_ALPHA, 8'h00, 4'($urandom), 3'd0, 4'($urandom));
    push_item(dfa_pkg::OP_WRITE_ALPHA, 8'hFF, 4'($urandom), 3'd1, 4'($urandom));
    push_item(dfa_pkg::OP_WRITE_ALPHA, 8'h41, 4'($urandom), 3'd2, 4'($urandom));
    push_item(dfa_pkg::OP_WRITE_ALPHA, 8'h41, 4'($urandom), 3'd3, 4'($urandom));
    for (int c = 4; c < 8; c++)
      push_item(dfa_pkg::OP_WRITE_ALPHA, 8'($urandom), 4'($urandom), 3'(c), 4'($urandom));
    for (int s = 0; s < 16; s++)
      for (int c = 0; c < 8; c++)
        push_item(dfa_pkg::OP_WRITE_TRANS, 8'($urandom), 4'(s), 3'(c), 4'($urandom));
    settle();

    // directed: empty string, extremes, duplicates, bad character
    set_config(4'd3, 16'h8009, 4'd8);
    push_end();
    push_feed(8'h00);
    push_feed(8'hFF);
    push_end();
    push_feed(8'h41);
    push_end();
    push_feed(stranger_byte());
    push_feed(8'h00);
    push_end();
    // table writes in the middle of a string
    push_feed(gen_alpha[7]);
    push_item(dfa_pkg::OP_WRITE_TRANS, 8'h00, 4'd15, 3'd7, 4'd0);
    push_item(dfa_pkg::OP_WRITE_TRANS, 8'hFF, 4'd0, 3'd0, 4'd15);
    push_item(dfa_pkg::OP_WRITE_ALPHA, 8'h80, 4'd15, 3'd7, 4'd15);
    push_feed(8'h80);
    push_end();
    // leave a string open across the start state change
    push_feed(8'h00);
    settle();

    // no active column, then a count above the table size
    set_config(4'd15, 16'hFFFF, 4'd0);
    push_end();
    push_feed(8'h00);
    push_end();
    settle();
    set_config(4'd0, 16'h0000, 4'd15);
    push_feed(8'hFF);
    push_feed(gen_alpha[7]);
    push_end();
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick = $urandom_range(0, 5);
      mask = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      cnt = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      if (p == 0) set_config(4'd0, 16'hFFFF, 4'd8);
      else if (p == 1) set_config(4'd15, 16'h0000, 4'd1);
      else set_config(4'($urandom), mask, cnt);
      if (p == 2) hold_req = 1'b1;
      calm = (p == 4);
      random_phase(PHASE_ITEMS);
      settle();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
